>>> rtl/lbdg_pkg.sv
package lbdg_pkg;

  localparam int FREQ_W = 22;
  localparam int LOAD_W = 7;
  localparam int SLOT_W = 4;
  localparam int HOLD_W = 5;
  localparam int ENTRIES_W = 5;
  localparam int PROD_W = FREQ_W + LOAD_W;
  localparam int COL_W = 4;

  localparam int FREQ_TABLE_DEPTH_DEF = 16;

  // stream packing
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = FREQ_W;

  // input item kinds on tuser
  localparam logic ACTION_TABLE = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  // request relation on tuser
  localparam logic REL_AT_OR_BELOW = 1'b0;
  localparam logic REL_AT_OR_ABOVE = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_TRIP = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOWN_MARGIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_FREQ = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DOWN_HOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POWERSAVE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MIN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY_MAX = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_ENTRIES = 3'd7;

  // register reset values
  localparam logic [LOAD_W-1:0] LOAD_TRIP_RST = 7'd90;
  localparam logic [LOAD_W-1:0] DOWN_MARGIN_RST = 7'd20;
  localparam logic [FREQ_W-1:0] FLOOR_FREQ_RST = 22'd960000;
  localparam logic [HOLD_W-1:0] DOWN_HOLD_RST = 5'd4;
  localparam logic [FREQ_W-1:0] POLICY_MIN_RST = 22'd0;
  localparam logic [FREQ_W-1:0] POLICY_MAX_RST = 22'd4000000;
  localparam logic [ENTRIES_W-1:0] TABLE_ENTRIES_RST = 5'd0;

  localparam logic [FREQ_W-1:0] BURST_BELOW = 22'd800000;
  localparam logic [LOAD_W-1:0] LEVEL_HIGH = 7'd95;
  localparam logic [LOAD_W-1:0] LEVEL_LOW = 7'd85;
  localparam logic [COL_W-1:0] LAST_COL = 4'd11;
  localparam logic [2:0] PS_ROW_OFFSET = 3'd3;

  localparam logic [FREQ_W-1:0] FREQ_MAP [6][12] = '{
    '{22'd616400, 22'd757200, 22'd840000, 22'd960000, 22'd1248000, 22'd1324800,
      22'd1478400, 22'd1593600, 22'd1632000, 22'd1728000, 22'd1824000, 22'd1996000},
    '{22'd773040, 22'd899760, 22'd1014960, 22'd1072560, 22'd1248000, 22'd1324800,
      22'd1478400, 22'd1593600, 22'd1632000, 22'd1728000, 22'd1824000, 22'd1996000},
    '{22'd851100, 22'd956700, 22'd1052700, 22'd1100700, 22'd1350400, 22'd1416000,
      22'd1593600, 22'd1708800, 22'd1824000, 22'd1996000, 22'd2073000, 22'd2150000},
    '{22'd616400, 22'd757200, 22'd840000, 22'd960000, 22'd1248000, 22'd1324800,
      22'd1478400, 22'd1593600, 22'd1593600, 22'd1593600, 22'd1593600, 22'd1593600},
    '{22'd773040, 22'd899760, 22'd1014960, 22'd1072560, 22'd1248000, 22'd1324800,
      22'd1478400, 22'd1593600, 22'd1593600, 22'd1593600, 22'd1593600, 22'd1593600},
    '{22'd851100, 22'd956700, 22'd1052700, 22'd1100700, 22'd1324800, 22'd1416000,
      22'd1593600, 22'd1708800, 22'd1708800, 22'd1708800, 22'd1708800, 22'd1708800}
  };

endpackage

>>> rtl/load_based_dvfs_governor_core.sv
// channel  | direction | handshake                    | contents
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | table entry or load sample
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | frequency request
// cfg      | in        | cfg_valid/cfg_ready          | register index and data
//
// a table entry writes the table memory as it is taken
// a sample with no request closes the input only through the decision step; the up path
// reads and compares table entries in turn (at most 11 searched), the down path runs the
// 29-step serial divider; the request turns valid as the input reopens
// rst is synchronous; the table memory is not cleared and holds garbage until written
// a waiting result stalls only the next sample at its emit step; cfg is always ready
module load_based_dvfs_governor_core
  import lbdg_pkg::*;
#(
  parameter int FREQ_TABLE_DEPTH = FREQ_TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] entry_slot, [25:4] entry_freq, [32:26] load_pct, [54:33] current_freq
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [21:0] requested frequency
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] relation
  output logic                   m_axis_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (FREQ_TABLE_DEPTH > 1) ? $clog2(FREQ_TABLE_DEPTH) : 1;
  localparam logic [6:0] DEPTH7 = 7'(FREQ_TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UP   = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // configuration registers
  logic [LOAD_W-1:0]    load_trip;
  logic [LOAD_W-1:0]    down_margin;
  logic [FREQ_W-1:0]    floor_freq;
  logic [HOLD_W-1:0]    down_hold_factor;
  logic                 powersave_mode;
  logic [FREQ_W-1:0]    policy_min_freq;
  logic [FREQ_W-1:0]    policy_top_freq;
  logic [ENTRIES_W-1:0] table_entries;

  logic [2:0]        state;
  logic [LOAD_W-1:0] previous_load;
  logic [HOLD_W-1:0] floor_counter;

  // sample being worked on
  logic [LOAD_W-1:0] load;
  logic [FREQ_W-1:0] cur;
  logic [PROD_W-1:0] lf;
  logic [LOAD_W-1:0] avg;
  logic [COL_W-1:0]  idx;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  n_lim;

  logic [FREQ_W-1:0] res_freq;
  logic              res_rel;
  logic [FREQ_W-1:0] out_freq;
  logic              out_rel;
  logic              emit_now;

  logic              s_accept;
  logic [SLOT_W-1:0] in_slot;
  logic [FREQ_W-1:0] in_entry;
  logic [LOAD_W-1:0] in_load;
  logic [FREQ_W-1:0] in_cur;
  logic [LOAD_W:0]   load_sum;

  logic              tbl_we;
  logic [7:0]        waddr_w;
  logic [7:0]        raddr_w;
  logic [FREQ_W-1:0] tbl_rdata;

  logic              up_path;
  logic [LOAD_W-1:0] margin;
  logic              down_go;
  logic [HOLD_W:0]   fc_inc;
  logic [HOLD_W-1:0] fc_down;
  logic [6:0]        n_ent;

  logic              burst;
  logic [1:0]        row;
  logic [2:0]        map_row;
  logic [FREQ_W-1:0] up_pick;
  logic [FREQ_W-1:0] up_next;

  logic              div_start;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [FREQ_W-1:0] q22;
  logic [FREQ_W-1:0] q_min;

  assign in_slot  = s_axis_tdata[3:0];
  assign in_entry = s_axis_tdata[25:4];
  assign in_load  = s_axis_tdata[32:26];
  assign in_cur   = s_axis_tdata[54:33];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign load_sum = {1'b0, previous_load} + {1'b0, in_load};
  assign emit_now = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // slots beyond the table are dropped
  assign tbl_we = s_accept && (s_axis_tuser == ACTION_TABLE) && ({3'b0, in_slot} < DEPTH7);
  assign waddr_w = {4'b0, in_slot};
  assign raddr_w = {4'b0, idx};

  // never a read and a write to the same entry in flight: one item at a time
  lbdg_ram #(
    .WIDTH(FREQ_W),
    .DEPTH(FREQ_TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(waddr_w[AW-1:0]),
    .wdata(in_entry),
    .raddr(raddr_w[AW-1:0]),
    .rdata(tbl_rdata)
  );

  assign div_start = (state == ST_DEC) && !up_path && (cur != policy_min_freq) && down_go;

  lbdg_div #(
    .NW(PROD_W),
    .DW(LOAD_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(lf),
    .divisor (margin),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    up_path = (cur != '0) && (load > LEVEL_LOW);
    margin = load_trip - down_margin;
    down_go = (load_trip > down_margin) && (cur != '0) && (load < margin);
    fc_inc = {1'b0, floor_counter} + (HOLD_W + 1)'(1);
    if (cur >= floor_freq) begin
      fc_down = (fc_inc > {1'b0, down_hold_factor}) ? '0 : fc_inc[HOLD_W-1:0];
    end else begin
      fc_down = '0;
    end
    n_ent = ({2'b0, table_entries} > DEPTH7) ? DEPTH7 : {2'b0, table_entries};
    n_lim = (n_ent > {3'b0, LAST_COL}) ? LAST_COL : n_ent[COL_W-1:0];

    burst = (cur < BURST_BELOW) && (load > LEVEL_HIGH);
    if (avg > LEVEL_HIGH) begin
      row = 2'd2;
    end else if (avg <= LEVEL_LOW) begin
      row = 2'd0;
    end else begin
      row = (load > LEVEL_HIGH) ? 2'd2 : 2'd1;
    end
    map_row = {1'b0, row} + (powersave_mode ? PS_ROW_OFFSET : 3'd0);
    up_pick = burst ? policy_top_freq : FREQ_MAP[map_row][col];
    up_next = (up_pick > policy_top_freq) ? policy_top_freq : up_pick;

    q22 = div_quo[FREQ_W-1:0];
    q_min = (q22 < policy_min_freq) ? policy_min_freq : q22;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_trip <= LOAD_TRIP_RST;
      down_margin <= DOWN_MARGIN_RST;
      floor_freq <= FLOOR_FREQ_RST;
      down_hold_factor <= DOWN_HOLD_RST;
      powersave_mode <= 1'b0;
      policy_min_freq <= POLICY_MIN_RST;
      policy_top_freq <= POLICY_MAX_RST;
      table_entries <= TABLE_ENTRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOAD_TRIP:     load_trip <= cfg_data[LOAD_W-1:0];
        REG_DOWN_MARGIN:   down_margin <= cfg_data[LOAD_W-1:0];
        REG_FLOOR_FREQ:    floor_freq <= cfg_data[FREQ_W-1:0];
        REG_DOWN_HOLD:     down_hold_factor <= cfg_data[HOLD_W-1:0];
        REG_POWERSAVE:     powersave_mode <= cfg_data[0];
        REG_POLICY_MIN:    policy_min_freq <= cfg_data[FREQ_W-1:0];
        REG_POLICY_MAX:    policy_top_freq <= cfg_data[FREQ_W-1:0];
        REG_TABLE_ENTRIES: table_entries <= cfg_data[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // sample payload and result staging
  always_ff @(posedge clk) begin
    if (s_accept) begin
      load <= in_load;
      cur <= in_cur;
      lf <= PROD_W'(in_load) * PROD_W'(in_cur);
      avg <= load_sum[LOAD_W:1];
    end
    if (state == ST_DEC) begin
      idx <= '0;
      col <= '0;
    end else if (state == ST_CMP) begin
      if (tbl_rdata >= cur) begin
        col <= idx;
      end else begin
        idx <= idx + COL_W'(1);
        col <= idx + COL_W'(1);
      end
    end
    if (state == ST_UP) begin
      res_freq <= up_next;
      res_rel <= REL_AT_OR_BELOW;
    end else if (state == ST_DIV && div_done) begin
      res_freq <= (floor_counter != '0) ? ((q22 < floor_freq) ? floor_freq : q22) : q_min;
      res_rel <= REL_AT_OR_ABOVE;
    end
    if (emit_now) begin
      out_freq <= res_freq;
      out_rel <= res_rel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      previous_load <= '0;
      floor_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_now) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept && s_axis_tuser == ACTION_SAMPLE) begin
            previous_load <= in_load;
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (up_path) begin
            state <= (n_lim == '0) ? ST_UP : ST_RD;
          end else if (cur != policy_min_freq) begin
            floor_counter <= fc_down;
            state <= down_go ? ST_DIV : ST_IDLE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          // the entry count is capped at the last map column, so the search stops there at the latest
          if (tbl_rdata >= cur || idx + COL_W'(1) == n_lim) begin
            state <= ST_UP;
          end else begin
            state <= ST_RD;
          end
        end
        ST_UP: begin
          if (up_next > floor_freq) begin
            floor_counter <= '0;
          end
          state <= ST_EMIT;
        end
        ST_DIV: begin
          if (div_done) begin
            if (floor_counter == '0 && q_min < floor_freq) begin
              floor_counter <= down_hold_factor;
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_now) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - FREQ_W)'(0), out_freq};
  assign m_axis_tuser = out_rel;

endmodule

>>> rtl/lbdg_ram.sv
module lbdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lbdg_div.sv
module lbdg_div #(
  parameter int NW = 29,
  parameter int DW = 7,
  localparam int CW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, quo[NW-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/lbdg_chk.sv
module lbdg_chk
  import lbdg_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  // no request left over from before reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("request valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled request changed");

  // a table entry never raises a request
  a_table_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACTION_TABLE && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("request after table entry");

  // a sample keeps the input closed while it is worked on
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACTION_SAMPLE |=> !s_axis_tready)
    else $error("input open right after a sample");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind load_based_dvfs_governor_core lbdg_chk u_lbdg_chk (.*);
